>>> src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

>>> src/scpa_pkg.sv
`default_nettype none
package scpa_pkg;

  localparam int NUM_GROUPS       = 4;
  localparam int CHUNKS_PER_GROUP = 16;
  localparam int NUM_REG_GROUPS   = 4;
  localparam int HANDLE_CHUNKS    = 16;

  localparam int SIZE_W    = 32;
  localparam int CNT_W     = 5;
  localparam int GRP_W     = 2;
  localparam int CHK_W     = 4;
  localparam int CFG_IDX_W = 3;

  localparam int USE_CHUNKS = (CHUNKS_PER_GROUP < HANDLE_CHUNKS) ?
                              CHUNKS_PER_GROUP : HANDLE_CHUNKS;
  localparam int LIM_W  = $clog2(USE_CHUNKS + 1);
  localparam int CIDX_W = (USE_CHUNKS > 1) ? $clog2(USE_CHUNKS) : 1;
  localparam int GSEL_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_BASE = CFG_IDX_W'(NUM_REG_GROUPS);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef logic [SIZE_W-1:0] word_t;
  typedef logic [NUM_GROUPS-1:0][SIZE_W-1:0] size_arr_t;
  typedef logic [NUM_GROUPS-1:0][LIM_W-1:0] lim_arr_t;

  typedef struct packed {
    word_t a;
    word_t b;
  } cmp_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A_SIZE,
    ST_A_SCAN,
    ST_F_SIZE,
    ST_F_CHUNK
  } state_t;

endpackage
`default_nettype wire

>>> src/size_class_pool_allocator.sv
// Free request: size compare, then chunk bound compare if group and size pass.
// Allocate request: per class one size compare, then, if it fits, a scan of its chunks up to
// the first free one or the limit; result strobe in the cycle after the last step.
// One request at a time; busy stays high until the result strobe, which lasts one cycle
// and cannot be stalled by the receiver.
// Synchronous reset clears all chunk occupancy and loads size 1 and count 0 in every class.
`default_nettype none
module size_class_pool_allocator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [scpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scpa_pkg::SIZE_W-1:0]     cfg_data,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            mode,
  input  wire logic [scpa_pkg::SIZE_W-1:0]     request_size,
  input  wire logic [scpa_pkg::GRP_W-1:0]      handle_group,
  input  wire logic [scpa_pkg::CHK_W-1:0]      handle_chunk,
  output logic                                 done,
  output logic                                 ok,
  output logic [scpa_pkg::GRP_W-1:0]           out_group,
  output logic [scpa_pkg::CHK_W-1:0]           out_chunk
);
  import scpa_pkg::*;

  size_arr_t sizes;
  lim_arr_t  limits;
  cmp_req_t  cmp_req;
  logic      ge;

  scpa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sizes     (sizes),
    .limits    (limits)
  );

  scpa_cmp u_cmp (
    .cmp_req (cmp_req),
    .ge      (ge)
  );

  scpa_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .mode         (mode),
    .request_size (request_size),
    .handle_group (handle_group),
    .handle_chunk (handle_chunk),
    .sizes        (sizes),
    .limits       (limits),
    .cmp_req      (cmp_req),
    .ge           (ge),
    .busy         (busy),
    .done         (done),
    .ok           (ok),
    .out_group    (out_group),
    .out_chunk    (out_chunk)
  );

endmodule
`default_nettype wire

>>> src/scpa_cfg.sv
`default_nettype none
module scpa_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [scpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scpa_pkg::SIZE_W-1:0]     cfg_data,
  output scpa_pkg::size_arr_t                  sizes,
  output scpa_pkg::lim_arr_t                   limits
);
  import scpa_pkg::*;

  logic [NUM_REG_GROUPS-1:0][SIZE_W-1:0] size_reg;
  logic [NUM_REG_GROUPS-1:0][CNT_W-1:0]  cnt_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REG_GROUPS; i++) begin
        size_reg[i] <= SIZE_W'(1);
        cnt_reg[i]  <= '0;
      end
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_REG_GROUPS; i++) begin
        if (cfg_index == REG_SIZE_BASE + CFG_IDX_W'(i)) begin
          size_reg[i] <= cfg_data;
        end
        if (cfg_index == REG_COUNT_BASE + CFG_IDX_W'(i)) begin
          cnt_reg[i] <= cfg_data[CNT_W-1:0];
        end
      end
    end
  end

  // Classes without registers keep size one and no chunks.
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (g < NUM_REG_GROUPS) begin
        sizes[g] = size_reg[g];
        if (32'(cnt_reg[g]) > USE_CHUNKS) begin
          limits[g] = LIM_W'(USE_CHUNKS);
        end else begin
          limits[g] = LIM_W'(cnt_reg[g]);
        end
      end else begin
        sizes[g]  = SIZE_W'(1);
        limits[g] = '0;
      end
    end
  end

endmodule
`default_nettype wire

>>> src/scpa_cmp.sv
`default_nettype none
module scpa_cmp (
  input  scpa_pkg::cmp_req_t cmp_req,
  output logic               ge
);
  import scpa_pkg::*;

  assign ge = (cmp_req.a >= cmp_req.b);

endmodule
`default_nettype wire

>>> src/scpa_seq.sv
`default_nettype none
module scpa_seq (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic                         mode,
  input  wire logic [scpa_pkg::SIZE_W-1:0]  request_size,
  input  wire logic [scpa_pkg::GRP_W-1:0]   handle_group,
  input  wire logic [scpa_pkg::CHK_W-1:0]   handle_chunk,
  input  scpa_pkg::size_arr_t               sizes,
  input  scpa_pkg::lim_arr_t                limits,
  output scpa_pkg::cmp_req_t                cmp_req,
  input  wire logic                         ge,
  output logic                              busy,
  output logic                              done,
  output logic                              ok,
  output logic [scpa_pkg::GRP_W-1:0]        out_group,
  output logic [scpa_pkg::CHK_W-1:0]        out_chunk
);
  import scpa_pkg::*;

  state_t                                   state, state_next;
  logic [GSEL_W-1:0]                        grp, grp_next;
  logic [LIM_W-1:0]                         chk, chk_next;
  word_t                                    req, req_next;
  logic [CHK_W-1:0]                         hc, hc_next;
  logic                                     hg_ok, hg_ok_next;
  logic [NUM_GROUPS-1:0][USE_CHUNKS-1:0]    used, used_next;
  logic                                     done_next, ok_next;
  logic [GRP_W-1:0]                         out_group_next;
  logic [CHK_W-1:0]                         out_chunk_next;
  logic [CIDX_W-1:0]                        scan_idx;
  logic [CIDX_W-1:0]                        free_idx;
  logic                                     last_grp;

  assign scan_idx = chk[CIDX_W-1:0];
  assign free_idx = hc[CIDX_W-1:0];
  assign last_grp = (grp == GSEL_W'(NUM_GROUPS - 1));
  assign busy     = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      used  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      done  <= done_next;
    end
    grp       <= grp_next;
    chk       <= chk_next;
    req       <= req_next;
    hc        <= hc_next;
    hg_ok     <= hg_ok_next;
    ok        <= ok_next;
    out_group <= out_group_next;
    out_chunk <= out_chunk_next;
  end

  always_comb begin
    state_next     = state;
    grp_next       = grp;
    chk_next       = chk;
    req_next       = req;
    hc_next        = hc;
    hg_ok_next     = hg_ok;
    used_next      = used;
    done_next      = 1'b0;
    ok_next        = ok;
    out_group_next = out_group;
    out_chunk_next = out_chunk;
    cmp_req.a      = sizes[grp];
    cmp_req.b      = req;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          req_next   = request_size;
          hc_next    = handle_chunk;
          hg_ok_next = (32'(handle_group) < NUM_GROUPS);
          if (mode == MODE_FREE) begin
            grp_next   = GSEL_W'(handle_group);
            state_next = ST_F_SIZE;
          end else begin
            grp_next   = '0;
            state_next = ST_A_SIZE;
          end
        end
      end
      ST_A_SIZE: begin
        if (ge) begin
          chk_next   = '0;
          state_next = ST_A_SCAN;
        end else if (last_grp) begin
          state_next     = ST_IDLE;
          done_next      = 1'b1;
          ok_next        = 1'b0;
          out_group_next = '0;
          out_chunk_next = '0;
        end else begin
          grp_next = grp + GSEL_W'(1);
        end
      end
      ST_A_SCAN: begin
        cmp_req.a = SIZE_W'(limits[grp]);
        cmp_req.b = SIZE_W'(chk) + SIZE_W'(1);
        if (!ge) begin
          if (last_grp) begin
            state_next     = ST_IDLE;
            done_next      = 1'b1;
            ok_next        = 1'b0;
            out_group_next = '0;
            out_chunk_next = '0;
          end else begin
            grp_next   = grp + GSEL_W'(1);
            state_next = ST_A_SIZE;
          end
        end else if (!used[grp][scan_idx]) begin
          used_next[grp][scan_idx] = 1'b1;
          state_next     = ST_IDLE;
          done_next      = 1'b1;
          ok_next        = 1'b1;
          out_group_next = GRP_W'(grp);
          out_chunk_next = CHK_W'(chk);
        end else begin
          chk_next = chk + LIM_W'(1);
        end
      end
      ST_F_SIZE: begin
        if (hg_ok && ge) begin
          state_next = ST_F_CHUNK;
        end else begin
          state_next     = ST_IDLE;
          done_next      = 1'b1;
          ok_next        = 1'b0;
          out_group_next = '0;
          out_chunk_next = '0;
        end
      end
      ST_F_CHUNK: begin
        cmp_req.a      = SIZE_W'(limits[grp]);
        cmp_req.b      = SIZE_W'(hc) + SIZE_W'(1);
        state_next     = ST_IDLE;
        done_next      = 1'b1;
        ok_next        = ge;
        out_group_next = '0;
        out_chunk_next = '0;
        if (ge) begin
          used_next[grp][free_idx] = 1'b0;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/scpa_chk.sv
`default_nettype none
`include "assert_macros.svh"
module scpa_chk (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            done,
  input wire logic                            ok,
  input wire logic [scpa_pkg::GRP_W-1:0]      out_group,
  input wire logic [scpa_pkg::CHK_W-1:0]      out_chunk
);
  import scpa_pkg::*;

  // A request that is taken keeps the block busy until its result.
  `ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  // The result appears exactly when the block stops being busy.
  `ASSERT_IMP(a_done_idle, clk, rst, done, !busy && $fell(busy))
  // The result strobe lasts one cycle.
  `ASSERT_NXT(a_done_pulse, clk, rst, done, !done)
  // A failed or rejected request reports a zero handle.
  `ASSERT_IMP(a_fail_zero, clk, rst, done && !ok, out_group == '0 && out_chunk == '0)

endmodule

bind size_class_pool_allocator scpa_chk u_scpa_chk (.*);
`default_nettype wire

>>> tb/sv/size_class_pool_allocator_test.sv
`timescale 1ns / 1ps
module size_class_pool_allocator_test;
  import scpa_pkg::*;

  typedef struct {
    logic             mode;
    logic [SIZE_W-1:0] req_size;
    logic [GRP_W-1:0] grp;
    logic [CHK_W-1:0] chunk;
  } request_t;

  typedef struct {
    logic             ok;
    logic [GRP_W-1:0] grp;
    logic [CHK_W-1:0] chunk;
  } grant_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_data = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 mode = MODE_ALLOC;
  logic [SIZE_W-1:0]    request_size = '0;
  logic [GRP_W-1:0]     handle_group = '0;
  logic [CHK_W-1:0]     handle_chunk = '0;
  logic                 done;
  logic                 ok;
  logic [GRP_W-1:0]     out_group;
  logic [CHK_W-1:0]     out_chunk;

  logic [SIZE_W-1:0]     group_size [NUM_GROUPS];
  logic [CNT_W-1:0]      group_count [NUM_GROUPS];
  logic [USE_CHUNKS-1:0] occupancy [NUM_GROUPS];

  request_t request_backlog [$];
  grant_t   awaited_grants [$];
  request_t in_flight;
  grant_t   next_grant;
  grant_t   due;
  int       gap_left = 0;
  bit       idle_enabled = 1'b0;
  int       mismatch_count = 0;

  size_class_pool_allocator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .start(start), .busy(busy), .mode(mode), .request_size(request_size),
    .handle_group(handle_group), .handle_chunk(handle_chunk), .done(done), .ok(ok),
    .out_group(out_group), .out_chunk(out_chunk)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int usable(int g);
    int c = group_count[g];
    if (c > USE_CHUNKS) c = USE_CHUNKS;
    return c;
  endfunction

  task automatic flag_mismatch(string what);
    if (mismatch_count < 40) $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  // Applies one request to the pool state and returns the result it must produce.
  task automatic serve_request(input request_t r, output grant_t g);
    bit hit;
    int lim;
    g = '{ok: 1'b0, grp: '0, chunk: '0};
    hit = 1'b0;
    if (r.mode == MODE_ALLOC) begin
      for (int k = 0; k < NUM_GROUPS && !hit; k++) begin
        if (group_size[k] >= r.req_size) begin
          lim = usable(k);
          for (int c = 0; c < lim && !hit; c++) begin
            if (!occupancy[k][c]) begin
              occupancy[k][c] = 1'b1;
              g.ok = 1'b1;
              g.grp = GRP_W'(k);
              g.chunk = CHK_W'(c);
              hit = 1'b1;
            end
          end
        end
      end
    end else if (int'(r.grp) < NUM_GROUPS && group_size[r.grp] >= r.req_size &&
                 int'(r.chunk) < usable(r.grp)) begin
      occupancy[r.grp][r.chunk] = 1'b0;
      g.ok = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        serve_request(in_flight, next_grant);
        awaited_grants = {awaited_grants, next_grant};
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 11);
          start <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          in_flight = request_backlog.pop_front();
          start <= 1'b1;
          mode <= in_flight.mode;
          request_size <= in_flight.req_size;
          handle_group <= in_flight.grp;
          handle_chunk <= in_flight.chunk;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_grants.size() == 0) begin
        flag_mismatch("result strobe with no request outstanding");
      end else begin
        due = awaited_grants.pop_front();
        if (ok !== due.ok) flag_mismatch($sformatf("ok %b, expected %b", ok, due.ok));
        if (out_group !== due.grp)
          flag_mismatch($sformatf("out_group %0d, expected %0d", out_group, due.grp));
        if (out_chunk !== due.chunk)
          flag_mismatch($sformatf("out_chunk %0d, expected %0d", out_chunk, due.chunk));
      end
    end
  end

  task automatic queue_request(logic md, logic [SIZE_W-1:0] sz, int g, int c);
    request_t r;
    r.mode = md;
    r.req_size = sz;
    r.grp = GRP_W'(g);
    r.chunk = CHK_W'(c);
    request_backlog = {request_backlog, r};
  endtask

  task automatic settle();
    do @(negedge clk);
    while (request_backlog.size() != 0 || start || busy || awaited_grants.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx < REG_COUNT_BASE) group_size[idx - REG_SIZE_BASE] = data;
    else group_count[idx - REG_COUNT_BASE] = data[CNT_W-1:0];
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Count writes may carry random upper bits, which the block must drop.
  task automatic program_groups(logic [SIZE_W-1:0] sz [NUM_GROUPS], int cnt [NUM_GROUPS]);
    logic [SIZE_W-1:0] junk;
    for (int g = 0; g < NUM_GROUPS; g++) write_reg(REG_SIZE_BASE + CFG_IDX_W'(g), sz[g]);
    for (int g = 0; g < NUM_GROUPS; g++) begin
      junk = ($urandom_range(0, 1) != 0) ? $urandom : '0;
      write_reg(REG_COUNT_BASE + CFG_IDX_W'(g),
                (junk & ~SIZE_W'(32'h1F)) | SIZE_W'(cnt[g]));
    end
    close_writes();
  endtask

  function automatic logic [SIZE_W-1:0] pick_size(bit for_free);
    int k = $urandom_range(0, NUM_GROUPS - 1);
    case ($urandom_range(0, 7))
      0, 1:    return group_size[k];
      2:       return group_size[k] + SIZE_W'(1);
      3:       return group_size[k] - SIZE_W'(1);
      4:       return '0;
      5:       return $urandom;
      6:       return for_free ? SIZE_W'($urandom_range(0, group_size[k])) : SIZE_W'(32'hFFFFFFFF);
      default: return SIZE_W'($urandom_range(0, 64));
    endcase
  endfunction

  task automatic random_phase(int n, int kind, bit idle_on);
    logic [SIZE_W-1:0] sz [NUM_GROUPS];
    int cnt [NUM_GROUPS];
    int sorted_sz [$];
    int alloc_pct;
    int g;
    int c;
    settle();
    for (int k = 0; k < NUM_GROUPS; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: sz[k] = $urandom_range(1, 64);
        5, 6:          sz[k] = $urandom_range(65, 4096);
        7:             sz[k] = $urandom;
        8:             sz[k] = 32'hFFFFFFFF;
        default:       sz[k] = ($urandom_range(0, 3) == 0) ? '0 : SIZE_W'(1);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: cnt[k] = $urandom_range(1, 16);
        6:                cnt[k] = 16;
        7:                cnt[k] = 0;
        8:                cnt[k] = $urandom_range(17, 31);
        default:          cnt[k] = $urandom_range(0, 4);
      endcase
      if (kind == 2) begin
        sz[k] = 32'hFFFFFFFF;
        cnt[k] = 16;
      end else if (kind == 3) begin
        sz[k] = (k < 2) ? '0 : SIZE_W'(1);
        cnt[k] = k;
      end
    end
    if (kind == 0) begin
      for (int k = 0; k < NUM_GROUPS; k++) sorted_sz = {sorted_sz, int'(sz[k])};
      sorted_sz.sort() with (longint'(unsigned'(item)));
      for (int k = 0; k < NUM_GROUPS; k++) sz[k] = SIZE_W'(sorted_sz[k]);
    end
    program_groups(sz, cnt);
    idle_enabled = idle_on;
    alloc_pct = 60;
    for (int i = 0; i < n; i++) begin
      if (i % 30 == 0) alloc_pct = $urandom_range(20, 90);
      if ($urandom_range(0, 9) == 0) begin
        queue_request($urandom_range(0, 1), $urandom, $urandom_range(0, 3),
                      $urandom_range(0, 15));
      end else if ($urandom_range(1, 100) <= alloc_pct) begin
        queue_request(MODE_ALLOC, pick_size(1'b0), $urandom_range(0, 3), $urandom_range(0, 15));
      end else begin
        g = $urandom_range(0, NUM_GROUPS - 1);
        c = (usable(g) > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, usable(g) - 1)
                                                           : $urandom_range(0, 15);
        queue_request(MODE_FREE, ($urandom_range(0, 2) != 0) ? group_size[g] : pick_size(1'b1),
                      g, c);
      end
    end
  endtask

  initial begin
    int guard;
    logic [SIZE_W-1:0] sz [NUM_GROUPS];
    int cnt [NUM_GROUPS];
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_size[g] = SIZE_W'(1);
      group_count[g] = '0;
      occupancy[g] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // With the reset settings no group has a chunk to give.
    queue_request(MODE_ALLOC, '0, 0, 0);
    queue_request(MODE_ALLOC, SIZE_W'(1), 3, 15);
    queue_request(MODE_FREE, '0, 0, 0);
    settle();

    sz = '{32'd4, 32'd16, 32'd1000, 32'hFFFFFFFF};
    cnt = '{2, 16, 1, 31};
    program_groups(sz, cnt);
    repeat (3) queue_request(MODE_ALLOC, SIZE_W'(4), 0, 0);
    queue_request(MODE_ALLOC, 32'hFFFFFFFF, 0, 0);
    queue_request(MODE_ALLOC, SIZE_W'(1001), 0, 0);
    queue_request(MODE_FREE, SIZE_W'(4), 0, 1);
    queue_request(MODE_FREE, SIZE_W'(4), 0, 1);
    queue_request(MODE_FREE, SIZE_W'(1), 0, 2);
    queue_request(MODE_FREE, SIZE_W'(17), 1, 0);
    queue_request(MODE_FREE, '0, 3, 15);
    queue_request(MODE_ALLOC, SIZE_W'(1), 0, 0);
    settle();

    // Shrinking a group hides the chunks that are still held above the new count.
    write_reg(REG_COUNT_BASE + CFG_IDX_W'(1), '0);
    write_reg(REG_COUNT_BASE + CFG_IDX_W'(0), SIZE_W'(1));
    write_reg(REG_SIZE_BASE, '0);
    close_writes();
    queue_request(MODE_FREE, SIZE_W'(4), 1, 0);
    queue_request(MODE_FREE, '0, 0, 1);
    queue_request(MODE_ALLOC, SIZE_W'(5), 0, 0);
    queue_request(MODE_ALLOC, '0, 0, 0);
    queue_request(MODE_FREE, '0, 0, 0);
    queue_request(MODE_ALLOC, '0, 0, 0);
    queue_request(MODE_ALLOC, SIZE_W'(1), 0, 0);
    settle();

    random_phase(220, 0, 1'b1);
    random_phase(220, 0, 1'b1);
    random_phase(220, 1, 1'b1);
    random_phase(220, 2, 1'b1);
    random_phase(220, 0, 1'b0);
    random_phase(200, 3, 1'b1);
    random_phase(220, 1, 1'b1);
    random_phase(220, 0, 1'b0);

    do @(negedge clk);
    while (request_backlog.size() != 0 || start);
    guard = 0;
    while (awaited_grants.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (80) @(negedge clk);
    if (awaited_grants.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", awaited_grants.size()));
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/scpa_pkg.sv
src/scpa_cfg.sv
src/scpa_cmp.sv
src/scpa_seq.sv
src/size_class_pool_allocator.sv
src/scpa_chk.sv
tb/sv/size_class_pool_allocator_test.sv
